[sv/scaled_matrix_multiply_accumulate_core_assert.svh]
// Assertion macros used by the port-level checker of the scaled matrix multiply-accumulate core
`ifndef SCALED_MATRIX_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH
`define SCALED_MATRIX_MULTIPLY_ACCUMULATE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define SMMAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define SMMAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/smmac_pkg.sv]
// Types, constants and microcode program of the scaled matrix multiply-accumulate core
package smmac_pkg;

    localparam int VAL_W     = 32;
    localparam int IDX_W     = 4;
    localparam int REQ_W     = 2;
    localparam int SIZE_W    = 5;
    localparam int GAIN_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RST  = 5'd16;
    localparam logic [GAIN_W-1:0] ALPHA_RST = 18'd6554;
    localparam logic [GAIN_W-1:0] BETA_RST  = 18'd32768;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_LOAD_C  = 2'd2,
        REQ_COMPUTE = 2'd3
    } t_req;

    // Multiplier operand pairs; also tells the accumulator where the product goes
    typedef enum logic [2:0] {
        MS_NONE,
        MS_AB,
        MS_BETA,
        MS_ALPHA0,
        MS_ALPHA1,
        MS_ALPHA2
    } t_mul_sel;

    // Jump conditions: jump to target when true, else advance
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_MORE_K,
        JC_OUT_BUSY,
        JC_NO_START
    } t_jcond;

    typedef logic [3:0] t_step;

    localparam t_step ST_CLR    = 4'd0;
    localparam t_step ST_LOOP   = 4'd1;
    localparam t_step ST_DRAIN  = 4'd2;
    localparam t_step ST_BETA   = 4'd3;
    localparam t_step ST_ALPHA0 = 4'd4;
    localparam t_step ST_ALPHA1 = 4'd5;
    localparam t_step ST_ALPHA2 = 4'd6;
    localparam t_step ST_SETTLE = 4'd7;
    localparam t_step ST_EMIT   = 4'd8;
    localparam t_step ST_IDLE   = 4'd9;
    localparam t_step ST_FIRST  = ST_CLR;
    localparam t_step ST_LAST   = ST_IDLE;

    typedef struct packed {
        logic     take;
        logic     clr;
        logic     rd_c;
        logic     rd_ab;
        t_mul_sel mul_sel;
        logic     emit;
        t_jcond   jcond;
        t_step    target;
    } t_ucode;

    typedef struct packed {
        logic     start;
        logic     clr;
        logic     rd_c;
        logic     rd_ab;
        t_mul_sel mul_sel;
        logic     emit;
    } t_dp_ctrl;

    typedef struct packed {
        logic cmp_ok;
        logic k_last;
        logic out_free;
    } t_dp_stat;

    function automatic t_ucode ucode_rom(input t_step pc);
        t_ucode w;
        w = '0;
        w.mul_sel = MS_NONE;
        w.jcond   = JC_NEVER;
        w.target  = ST_IDLE;
        case (pc)
            ST_CLR: begin
                w.clr  = 1'b1;
                w.rd_c = 1'b1;
            end
            ST_LOOP: begin
                w.rd_ab  = 1'b1;
                w.jcond  = JC_MORE_K;
                w.target = ST_LOOP;
            end
            ST_DRAIN: begin
            end
            ST_BETA: begin
                w.mul_sel = MS_BETA;
            end
            ST_ALPHA0: begin
                w.mul_sel = MS_ALPHA0;
            end
            ST_ALPHA1: begin
                w.mul_sel = MS_ALPHA1;
            end
            ST_ALPHA2: begin
                w.mul_sel = MS_ALPHA2;
            end
            ST_SETTLE: begin
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.jcond  = JC_OUT_BUSY;
                w.target = ST_EMIT;
            end
            ST_IDLE: begin
                w.take   = 1'b1;
                w.jcond  = JC_NO_START;
                w.target = ST_IDLE;
            end
            default: begin
                w.jcond  = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[sv/smmac_if.sv]
// Valid/ready word channels of the scaled matrix multiply-accumulate core
interface smmac_in_if;
    import smmac_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface smmac_out_if;
    import smmac_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;

    modport source (output valid, out_row, out_col, out_value, saturated, input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, output ready);
endinterface

[sv/smmac_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic
module smmac_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  smmac_pkg::t_dp_stat i_stat,
    output smmac_pkg::t_dp_ctrl o_ctrl,
    output logic                o_in_ready
);
    import smmac_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_ucode cw;
    logic   jump;
    logic   start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        cw    = ucode_rom(r_pc);
        start = cw.take && i_in_valid && i_stat.cmp_ok;
        case (cw.jcond)
            JC_NEVER:    jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_MORE_K:   jump = !i_stat.k_last;
            JC_OUT_BUSY: jump = !i_stat.out_free;
            JC_NO_START: jump = !start;
            default:     jump = 1'b0;
        endcase
        if (jump) begin
            n_pc = cw.target;
        end else if (r_pc == ST_LAST) begin
            n_pc = ST_FIRST;
        end else begin
            n_pc = r_pc + 1'b1;
        end

        o_ctrl.start   = start;
        o_ctrl.clr     = cw.clr;
        o_ctrl.rd_c    = cw.rd_c;
        o_ctrl.rd_ab   = cw.rd_ab;
        o_ctrl.mul_sel = cw.mul_sel;
        // drop the emit pulse while the output register still holds an untaken word
        o_ctrl.emit    = cw.emit && i_stat.out_free;
        o_in_ready     = cw.take;
    end

endmodule

[sv/smmac_dp.sv]
// Datapath: config registers, matrix memories, shared multiplier, accumulators, output register
module smmac_dp #(
    parameter int MAX_DIM = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [smmac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smmac_pkg::GAIN_W-1:0]        i_cfg_data,
    input  logic                                i_in_accept,
    input  logic [smmac_pkg::REQ_W-1:0]         i_req_type,
    input  logic [smmac_pkg::IDX_W-1:0]         i_row,
    input  logic [smmac_pkg::IDX_W-1:0]         i_col,
    input  logic signed [smmac_pkg::VAL_W-1:0]  i_value,
    input  smmac_pkg::t_dp_ctrl                 i_ctrl,
    output smmac_pkg::t_dp_stat                 o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [smmac_pkg::IDX_W-1:0]         o_out_row,
    output logic [smmac_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [smmac_pkg::VAL_W-1:0]  o_out_value,
    output logic                                o_saturated
);
    import smmac_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_DIM);
    localparam int ACC_W = 65 + $clog2(MAX_DIM);
    localparam int RES_W = ACC_W + 20;

    // configuration
    logic [SIZE_W-1:0] r_size;
    logic [GAIN_W-1:0] r_alpha;
    logic [GAIN_W-1:0] r_beta;

    // item position
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [AW-1:0]    r_pos;
    logic [KW-1:0]    r_nm1;
    logic [KW-1:0]    r_k;

    // memories and their read registers
    logic [VAL_W-1:0] r_mem_a [DEPTH];
    logic [VAL_W-1:0] r_mem_b [DEPTH];
    logic [VAL_W-1:0] r_mem_c [DEPTH];
    logic [VAL_W-1:0] r_a_q;
    logic [VAL_W-1:0] r_b_q;
    logic [VAL_W-1:0] r_c_q;
    logic             r_ab_v;

    // arithmetic
    logic signed [PROD_W-1:0] r_prod;
    t_mul_sel                 r_psel;
    logic signed [ACC_W-1:0]  r_dot;
    logic signed [RES_W-1:0]  r_sum;

    // output register
    logic             r_ovalid;
    logic [IDX_W-1:0] r_orow;
    logic [IDX_W-1:0] r_ocol;
    logic [VAL_W-1:0] r_oval;
    logic             r_osat;

    t_req                    req;
    logic                    pos_ok;
    logic                    load_we;
    logic [AW-1:0]           in_pos;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [KW-1:0]           nm1;
    t_mul_sel                mul_op;
    logic signed [MUL_W-1:0] ma;
    logic signed [MUL_W-1:0] mb;
    logic signed [RES_W-1:0] prod_ext;
    logic [RES_W-64:0]       sum_hi;
    logic                    fits;
    logic [VAL_W-1:0]        res;
    logic                    c_we;
    logic [AW-1:0]           c_wa;
    logic [VAL_W-1:0]        c_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RST;
            r_alpha <= ALPHA_RST;
            r_beta  <= BETA_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_BETA:  r_beta  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        req     = t_req'(i_req_type);
        pos_ok  = (32'(i_row) < 32'(MAX_DIM)) && (32'(i_col) < 32'(MAX_DIM));
        load_we = i_in_accept && pos_ok && (req != REQ_COMPUTE);
        in_pos  = AW'(32'(i_row) * 32'(MAX_DIM) + 32'(i_col));
        addr_a  = AW'(32'(r_row) * 32'(MAX_DIM) + 32'(r_k));
        addr_b  = AW'(32'(r_k) * 32'(MAX_DIM) + 32'(r_col));

        // clamp the size in use to 1..MAX_DIM and keep the last term index
        if (r_size == '0) begin
            nm1 = '0;
        end else if (32'(r_size) > 32'(MAX_DIM)) begin
            nm1 = KW'(MAX_DIM - 1);
        end else begin
            nm1 = KW'(r_size - 1'b1);
        end

        o_stat.cmp_ok   = (req == REQ_COMPUTE) && pos_ok;
        o_stat.k_last   = (r_k == r_nm1);
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_row <= i_row;
            r_col <= i_col;
            r_pos <= in_pos;
            r_nm1 <= nm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_ab_v <= 1'b0;
        end else begin
            r_ab_v <= i_ctrl.rd_ab;
            if (i_ctrl.clr) begin
                r_k <= '0;
            end else if (i_ctrl.rd_ab) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we && (req == REQ_LOAD_A)) begin
            r_mem_a[in_pos] <= i_value;
        end
        if (i_ctrl.rd_ab) begin
            r_a_q <= r_mem_a[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we && (req == REQ_LOAD_B)) begin
            r_mem_b[in_pos] <= i_value;
        end
        if (i_ctrl.rd_ab) begin
            r_b_q <= r_mem_b[addr_b];
        end
    end

    always_comb begin
        c_we = (load_we && (req == REQ_LOAD_C)) || i_ctrl.emit;
        c_wa = i_ctrl.emit ? r_pos : in_pos;
        c_wd = i_ctrl.emit ? res : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem_c[c_wa] <= c_wd;
        end
        if (i_ctrl.rd_c) begin
            r_c_q <= r_mem_c[r_pos];
        end
    end

    // the A/B stream owns the multiplier whenever read data is pending
    always_comb begin
        mul_op = r_ab_v ? MS_AB : i_ctrl.mul_sel;
        case (mul_op)
            MS_AB: begin
                ma = {r_a_q[VAL_W-1], r_a_q};
                mb = {r_b_q[VAL_W-1], r_b_q};
            end
            MS_BETA: begin
                ma = {r_c_q[VAL_W-1], r_c_q};
                mb = MUL_W'(r_beta);
            end
            MS_ALPHA0: begin
                ma = {1'b0, r_dot[31:0]};
                mb = MUL_W'(r_alpha);
            end
            MS_ALPHA1: begin
                ma = {1'b0, r_dot[63:32]};
                mb = MUL_W'(r_alpha);
            end
            MS_ALPHA2: begin
                ma = MUL_W'(signed'(r_dot[ACC_W-1:64]));
                mb = MUL_W'(r_alpha);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psel <= MS_NONE;
        end else begin
            r_psel <= mul_op;
        end
    end

    assign prod_ext = RES_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_dot <= '0;
            // preload the rounding half so the emit step only truncates
            r_sum <= RES_W'(VAL_MIN);
        end else begin
            case (r_psel)
                MS_AB:     r_dot <= r_dot + ACC_W'(r_prod);
                MS_BETA:   r_sum <= r_sum + (prod_ext <<< 16);
                MS_ALPHA0: r_sum <= r_sum + prod_ext;
                MS_ALPHA1: r_sum <= r_sum + (prod_ext <<< 32);
                MS_ALPHA2: r_sum <= r_sum + (prod_ext <<< 64);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sum_hi = r_sum[RES_W-1:63];
        fits   = (sum_hi == '0) || (sum_hi == '1);
        if (fits) begin
            res = r_sum[63:32];
        end else if (r_sum[RES_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_orow <= r_row;
            r_ocol <= r_col;
            r_oval <= res;
            r_osat <= !fits;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_value = r_oval;
    assign o_saturated = r_osat;

endmodule

[sv/scaled_matrix_multiply_accumulate_core.sv]
// Top level of the scaled matrix multiply-accumulate core
// Computes one entry of C = beta*C + alpha*(A*B) per compute word, with A, B and C
// held in on-chip memories of MAX_DIM*MAX_DIM words that load words fill one element
// at a time. A load word is taken every cycle while no compute runs. A compute word
// steps through CLR, LOOP, DRAIN, BETA, ALPHA0-2, SETTLE and EMIT before the block
// takes words again. With n the size in use clamped to 1..MAX_DIM, the inner product
// runs one multiply-accumulate per cycle for n terms through a single shared 33x33
// multiplier fed by one read port each on the A and B memories, followed by four
// multiplier passes for the beta and alpha scaling. Input ready is low while a
// compute runs; a finished result sits in an output register and only holds the
// sequencer when a second result is ready before the first is taken. Entries are
// rounded to Q16.16 (halves up) and clipped to 32 bits with the saturated flag set.
// Memories are not cleared after reset; read only entries that have been loaded.
module scaled_matrix_multiply_accumulate_core #(
    parameter int MAX_DIM = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [smmac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [smmac_pkg::GAIN_W-1:0]    i_cfg_data,
    smmac_in_if.sink                        i_in,
    smmac_out_if.source                     o_out
);
    import smmac_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;
    logic     in_ready;
    logic     in_accept;

    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    smmac_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (in_ready)
    );

    smmac_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (in_accept),
        .i_req_type  (i_in.req_type),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_value     (i_in.value),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_out_value (o_out.out_value),
        .o_saturated (o_out.saturated)
    );

endmodule

[sv/smmac_chk.sv]
// Port-level checker for the scaled matrix multiply-accumulate core, bound to the top level
`include "scaled_matrix_multiply_accumulate_core_assert.svh"

module smmac_chk #(
    parameter int MAX_DIM = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [smmac_pkg::REQ_W-1:0] i_req_type,
    input logic [smmac_pkg::IDX_W-1:0] i_row,
    input logic [smmac_pkg::IDX_W-1:0] i_col,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [smmac_pkg::VAL_W-1:0] i_out_value,
    input logic                        i_saturated
);
    import smmac_pkg::*;

    logic cmp_take;

    assign cmp_take = i_in_valid && i_in_ready && (i_req_type == REQ_COMPUTE)
                      && (32'(i_row) < 32'(MAX_DIM)) && (32'(i_col) < 32'(MAX_DIM));

    `SMMAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped before it was taken")
    `SMMAC_ASSERT_NXT(a_cmp_blocks_in, i_clk, i_rst_n, cmp_take, !i_in_ready, "input still ready after a compute word was taken")
    `SMMAC_ASSERT_IMP(a_out_from_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result appeared while the block was idle")
    `SMMAC_ASSERT_IMP(a_sat_clip, i_clk, i_rst_n, i_out_valid && i_saturated, (i_out_value == VAL_MAX) || (i_out_value == VAL_MIN), "saturated flag without a clipped value")

endmodule

bind scaled_matrix_multiply_accumulate_core smmac_chk #(
    .MAX_DIM (MAX_DIM)
) u_smmac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_req_type  (i_in.req_type),
    .i_row       (i_in.row),
    .i_col       (i_in.col),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value),
    .i_saturated (o_out.saturated)
);

[bench/smmac_checker.sv]
// Entry checker: tracks the A, B and C stores, predicts each computed C entry and compares
module smmac_checker
    import smmac_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    smmac_in_if                  i_in,
    smmac_out_if                 i_out,
    output int                   o_fail_count,
    output int                   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             saturated;
    } t_c_entry;

    logic signed [VAL_W-1:0] a_store [MAX_DIM][MAX_DIM];
    logic signed [VAL_W-1:0] b_store [MAX_DIM][MAX_DIM];
    logic signed [VAL_W-1:0] c_store [MAX_DIM][MAX_DIM];
    logic [SIZE_W-1:0]       size_reg;
    logic [GAIN_W-1:0]       alpha_reg;
    logic [GAIN_W-1:0]       beta_reg;
    t_c_entry                due_c_entries [$];
    int                      fails;

    // beta*C + alpha*(row of A . column of B), rounded half up to Q16.16, then clipped
    function automatic t_c_entry update_c_entry(input logic [IDX_W-1:0] r, c);
        logic signed [127:0] dot;
        logic signed [127:0] a_w;
        logic signed [127:0] b_w;
        logic signed [127:0] c_w;
        logic signed [127:0] gain_w;
        logic signed [127:0] total;
        logic signed [127:0] rounded;
        int                  n;
        t_c_entry            e;
        n = (size_reg == 0) ? 1 : ((size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg));
        dot = '0;
        for (int k = 0; k < n; k++) begin
            a_w = 128'(a_store[r][k]);
            b_w = 128'(b_store[k][c]);
            dot = dot + a_w * b_w;
        end
        gain_w = 128'(alpha_reg);
        total = dot * gain_w;
        c_w = 128'(c_store[r][c]);
        gain_w = 128'(beta_reg);
        total = total + ((c_w * gain_w) <<< 16) + (128'sd1 <<< 31);
        rounded = total >>> 32;
        e.row = r;
        e.col = c;
        if (rounded > 128'sd2147483647) begin
            e.value     = VAL_MAX;
            e.saturated = 1'b1;
        end else if (rounded < -128'sd2147483648) begin
            e.value     = VAL_MIN;
            e.saturated = 1'b1;
        end else begin
            e.value     = rounded[VAL_W-1:0];
            e.saturated = 1'b0;
        end
        c_store[r][c] = e.value;
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_c_entry got;
        t_c_entry want;
        if (!i_rst_n) begin
            size_reg  = SIZE_RST;
            alpha_reg = ALPHA_RST;
            beta_reg  = BETA_RST;
            due_c_entries.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SIZE:  size_reg  = i_cfg_data[SIZE_W-1:0];
                    CFG_ALPHA: alpha_reg = i_cfg_data;
                    CFG_BETA:  beta_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.row       = i_out.out_row;
                got.col       = i_out.out_col;
                got.value     = i_out.out_value;
                got.saturated = i_out.saturated;
                if (due_c_entries.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected word (%0d,%0d) value %h sat %0b", $realtime,
                                 got.row, got.col, got.value, got.saturated);
                end else begin
                    want = due_c_entries.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected (%0d,%0d) value %h sat %0b, got (%0d,%0d) value %h sat %0b",
                                     $realtime, want.row, want.col, want.value, want.saturated,
                                     got.row, got.col, got.value, got.saturated);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (t_req'(i_in.req_type))
                    REQ_LOAD_A: a_store[i_in.row][i_in.col] = i_in.value;
                    REQ_LOAD_B: b_store[i_in.row][i_in.col] = i_in.value;
                    REQ_LOAD_C: c_store[i_in.row][i_in.col] = i_in.value;
                    default:    due_c_entries.push_back(update_c_entry(i_in.row, i_in.col));
                endcase
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= due_c_entries.size();
    end

endmodule

[bench/tb_scaled_matrix_multiply_accumulate_core.sv]
// Stimulus and verdict for the scaled matrix multiply-accumulate core
module tb_scaled_matrix_multiply_accumulate_core;
    timeunit 1ns;
    timeprecision 1ps;
    import smmac_pkg::*;

    localparam int MAX_DIM        = 16;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 30;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 305;
    localparam int DIRECTED_WORDS = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [VAL_W-1:0]     Q_ONE     = 32'h0001_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   send_idle_pct;
    int                   take_idle_pct;
    int                   words_sent;
    logic [SIZE_W-1:0]    size_now;
    bit                   a_loaded [MAX_DIM][MAX_DIM];
    bit                   b_loaded [MAX_DIM][MAX_DIM];
    bit                   c_loaded [MAX_DIM][MAX_DIM];

    smmac_in_if  in_ch ();
    smmac_out_if out_ch ();

    scaled_matrix_multiply_accumulate_core #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    smmac_checker #(.MAX_DIM(MAX_DIM)) u_entry_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    // End the run after too many cycles with no word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [VAL_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            4:          return 32'($urandom_range(0, 64)) - 32'd32;
            5, 6:       return $urandom();
            7:          return VAL_MAX;
            8:          return VAL_MIN;
            default:    return '0;
        endcase
    endfunction

    task automatic send_word(input t_req req, input int r, input int c,
                             input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.row      <= r[IDX_W-1:0];
        in_ch.col      <= c[IDX_W-1:0];
        in_ch.value    <= val;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        words_sent++;
        case (req)
            REQ_LOAD_A: a_loaded[r][c] = 1'b1;
            REQ_LOAD_B: b_loaded[r][c] = 1'b1;
            REQ_LOAD_C: c_loaded[r][c] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Drop valid, wait for every entry to come back, then let the core go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int p);
        logic [SIZE_W-1:0] sz;
        logic [GAIN_W-1:0] alpha;
        logic [GAIN_W-1:0] beta;
        logic [GAIN_W-1:0] data;
        case (p)
            0: begin sz = 5'd1;  alpha = '1;          beta = '0;          end
            1: begin sz = 5'd16; alpha = '0;          beta = '1;          end
            2: begin sz = 5'd0;  alpha = ALPHA_RST;   beta = BETA_RST;    end
            3: begin
                sz    = 5'd31;
                alpha = GAIN_W'($urandom());
                beta  = GAIN_W'($urandom());
            end
            4: begin
                sz    = 5'($urandom_range(2, 15));
                alpha = 18'd65536;
                beta  = GAIN_W'($urandom());
            end
            default: begin sz = 5'd17; alpha = GAIN_W'($urandom()); beta = 18'd65536; end
        endcase
        size_now = sz;
        // Random upper bits check that the size register keeps only its own width
        data = GAIN_W'($urandom());
        data[SIZE_W-1:0] = sz;
        write_reg(CFG_SIZE, data);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_SPARE, GAIN_W'($urandom()));
        cfg_wr_en <= 1'b0;
    endtask

    // Refresh a few operands, load whatever the entry still lacks, then compute it
    task automatic run_compute();
        int n;
        int r;
        int c;
        int k;
        n = (size_now == 0) ? 1 : ((size_now > MAX_DIM) ? MAX_DIM : int'(size_now));
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DIM - 1) : $urandom_range(0, n - 1);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DIM - 1) : $urandom_range(0, n - 1);
        repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 2))
                0:       send_word(REQ_LOAD_A, r, k, random_element());
                1:       send_word(REQ_LOAD_B, k, c, random_element());
                default: send_word(REQ_LOAD_C, r, c, random_element());
            endcase
        end
        for (k = 0; k < n; k++) begin
            if (!a_loaded[r][k]) send_word(REQ_LOAD_A, r, k, random_element());
            if (!b_loaded[k][c]) send_word(REQ_LOAD_B, k, c, random_element());
        end
        if (!c_loaded[r][c]) send_word(REQ_LOAD_C, r, c, random_element());
        send_word(REQ_COMPUTE, r, c, $urandom());
        // Chain on the entry just written back
        if ($urandom_range(0, 3) == 0) send_word(REQ_COMPUTE, r, c, $urandom());
    endtask

    initial begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_SIZE;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= REQ_LOAD_A;
        in_ch.row      <= '0;
        in_ch.col      <= '0;
        in_ch.value    <= '0;
        send_idle_pct = 38;
        take_idle_pct = 83;
        words_sent    = 0;
        size_now      = SIZE_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        size_now = 5'd2;
        write_reg(CFG_SIZE, 18'd2);
        write_reg(CFG_ALPHA, '1);
        write_reg(CFG_BETA, '1);
        cfg_wr_en <= 1'b0;

        // Largest positive operands: clip high
        send_word(REQ_LOAD_A, 0, 0, VAL_MAX);
        send_word(REQ_LOAD_A, 0, 1, VAL_MAX);
        send_word(REQ_LOAD_B, 0, 0, VAL_MAX);
        send_word(REQ_LOAD_B, 1, 0, VAL_MAX);
        send_word(REQ_LOAD_C, 0, 0, VAL_MAX);
        send_word(REQ_COMPUTE, 0, 0, '0);
        // Corner entry beyond the size in use, most negative A and C entries: clip low
        send_word(REQ_LOAD_A, 15, 0, VAL_MIN);
        send_word(REQ_LOAD_A, 15, 1, '0);
        send_word(REQ_LOAD_B, 0, 15, VAL_MAX);
        send_word(REQ_LOAD_B, 1, 15, 32'h1234_5678);
        send_word(REQ_LOAD_C, 15, 15, VAL_MIN);
        send_word(REQ_COMPUTE, 15, 15, '1);
        // Small values that exercise rounding, computed twice to use the write-back
        send_word(REQ_LOAD_A, 3, 0, Q_ONE);
        send_word(REQ_LOAD_A, 3, 1, -Q_ONE);
        send_word(REQ_LOAD_B, 0, 12, 32'h0000_8000);
        send_word(REQ_LOAD_B, 1, 12, 32'h0000_0001);
        send_word(REQ_LOAD_C, 3, 12, 32'hFFFF_FFFF);
        send_word(REQ_COMPUTE, 3, 12, '0);
        send_word(REQ_COMPUTE, 3, 12, '0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            configure(p);
            if (p == 2) begin
                send_idle_pct = 83;
                take_idle_pct = 38;
            end else if (p == 4) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            while (words_sent < DIRECTED_WORDS + (p + 1) * PHASE_WORDS) begin
                if ($urandom_range(0, 99) < 60)
                    run_compute();
                else
                    send_word(t_req'($urandom_range(0, 2)), $urandom_range(0, MAX_DIM - 1),
                              $urandom_range(0, MAX_DIM - 1), random_element());
            end
        end
        settle();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/smmac_pkg.sv
sv/smmac_if.sv
sv/smmac_seq.sv
sv/smmac_dp.sv
sv/scaled_matrix_multiply_accumulate_core.sv
sv/smmac_chk.sv
bench/smmac_checker.sv
bench/tb_scaled_matrix_multiply_accumulate_core.sv
